### design/pbxd_pkg.sv
// ----------------------------------------------------------------------------
// pbxd_pkg
// Shared types and constants for the parallel bit extract/deposit pipeline.
// ----------------------------------------------------------------------------
package pbxd_pkg;

   localparam int DATA_WIDTH  = 64;
   localparam int GROUP_WIDTH = 8;
   localparam int NUM_GROUPS  = DATA_WIDTH / GROUP_WIDTH;
   localparam int IDX_W       = $clog2(DATA_WIDTH);
   localparam int LRANK_W     = $clog2(GROUP_WIDTH);
   localparam int GCNT_W      = $clog2(GROUP_WIDTH + 1);

   localparam logic CMD_EXTRACT = 1'b0;
   localparam logic CMD_DEPOSIT = 1'b1;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef struct packed {
      logic     valid;
      logic     command;
      word_type source_word;
      word_type select_mask;
   } item_type;

   typedef struct packed {
      item_type                              item;
      logic [DATA_WIDTH-1:0][LRANK_W-1:0]    lrank;
      logic [NUM_GROUPS-1:0][GCNT_W-1:0]     gcnt;
   } local_type;

   typedef struct packed {
      item_type                              item;
      logic [DATA_WIDTH-1:0][IDX_W-1:0]      rank;
   } rank_type;

endpackage

### design/parallel_bit_extract_deposit_core.sv
// Throughput: one item per cycle; busy stays low, start may be high every cycle.
// Three register stages: group rank, global rank, gather/scatter select.
// Reset clears the valid bits of all stages; items in flight are dropped.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
// parallel_bit_extract_deposit_core
// Pipelined 64-bit parallel bit extract and deposit unit.
// ----------------------------------------------------------------------------
module parallel_bit_extract_deposit_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  pbxd_pkg::word_type  req_source_word,
   input  pbxd_pkg::word_type  req_select_mask,
   output logic                rsp_valid,
   output pbxd_pkg::word_type  rsp_result_word
);

   pbxd_pkg::item_type  item_in;
   pbxd_pkg::local_type local_stage;
   pbxd_pkg::rank_type  rank_stage;

   assign busy = 1'b0;

   always_comb begin
      item_in.valid       = start & ~busy;
      item_in.command     = req_command;
      item_in.source_word = req_source_word;
      item_in.select_mask = req_select_mask;
   end

   pbxd_rank_local u_rank_local (
      .clock   (clock),
      .reset   (reset),
      .item_i  (item_in),
      .stage_o (local_stage)
   );

   pbxd_rank_global u_rank_global (
      .clock   (clock),
      .reset   (reset),
      .stage_i (local_stage),
      .stage_o (rank_stage)
   );

   pbxd_select u_select (
      .clock   (clock),
      .reset   (reset),
      .stage_i (rank_stage),
      .valid_o (rsp_valid),
      .word_o  (rsp_result_word)
   );

endmodule

### design/pbxd_rank_local.sv
// ----------------------------------------------------------------------------
// pbxd_rank_local
// Stage one: count set mask bits below each position inside its group.
// ----------------------------------------------------------------------------
module pbxd_rank_local (
   input  logic                clock,
   input  logic                reset,
   input  pbxd_pkg::item_type  item_i,
   output pbxd_pkg::local_type stage_o
);

   pbxd_pkg::local_type            stage_in;
   pbxd_pkg::local_type            stage_ff;
   logic [pbxd_pkg::GCNT_W-1:0]    run;

   always_comb begin
      stage_in      = '0;
      stage_in.item = item_i;
      run           = '0;
      for (int g = 0; g < pbxd_pkg::NUM_GROUPS; g++) begin
         run = '0;
         for (int b = 0; b < pbxd_pkg::GROUP_WIDTH; b++) begin
            stage_in.lrank[g*pbxd_pkg::GROUP_WIDTH+b] = pbxd_pkg::LRANK_W'(run);
            run = run + pbxd_pkg::GCNT_W'(item_i.select_mask[g*pbxd_pkg::GROUP_WIDTH+b]);
         end
         stage_in.gcnt[g] = run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.item.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

### design/pbxd_rank_global.sv
// ----------------------------------------------------------------------------
// pbxd_rank_global
// Stage two: add group base offsets to form the full rank of every position.
// ----------------------------------------------------------------------------
module pbxd_rank_global (
   input  logic                clock,
   input  logic                reset,
   input  pbxd_pkg::local_type stage_i,
   output pbxd_pkg::rank_type  stage_o
);

   pbxd_pkg::rank_type           stage_in;
   pbxd_pkg::rank_type           stage_ff;
   logic [pbxd_pkg::IDX_W-1:0]   base;

   always_comb begin
      stage_in      = '0;
      stage_in.item = stage_i.item;
      base          = '0;
      for (int g = 0; g < pbxd_pkg::NUM_GROUPS; g++) begin
         for (int b = 0; b < pbxd_pkg::GROUP_WIDTH; b++) begin
            stage_in.rank[g*pbxd_pkg::GROUP_WIDTH+b] =
               base + pbxd_pkg::IDX_W'(stage_i.lrank[g*pbxd_pkg::GROUP_WIDTH+b]);
         end
         base = base + pbxd_pkg::IDX_W'(stage_i.gcnt[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.item.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

### design/pbxd_select.sv
// ----------------------------------------------------------------------------
// pbxd_select
// Stage three: gather (extract) or scatter (deposit) bits by rank and register.
// ----------------------------------------------------------------------------
module pbxd_select (
   input  logic                clock,
   input  logic                reset,
   input  pbxd_pkg::rank_type  stage_i,
   output logic                valid_o,
   output pbxd_pkg::word_type  word_o
);

   pbxd_pkg::word_type word_in;
   pbxd_pkg::word_type word_ff;
   logic               valid_ff;

   always_comb begin
      word_in = '0;
      for (int i = 0; i < pbxd_pkg::DATA_WIDTH; i++) begin
         case (stage_i.item.command)
            pbxd_pkg::CMD_EXTRACT: begin
               if (stage_i.item.select_mask[i]) begin
                  word_in[stage_i.rank[i]] = word_in[stage_i.rank[i]]
                                             | stage_i.item.source_word[i];
               end
            end
            pbxd_pkg::CMD_DEPOSIT: begin
               word_in[i] = stage_i.item.select_mask[i]
                            & stage_i.item.source_word[stage_i.rank[i]];
            end
            default: begin
               word_in[i] = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_i.item.valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign valid_o = valid_ff;
   assign word_o  = word_ff;

endmodule

### design/pbxd_checker.sv
// ----------------------------------------------------------------------------
// pbxd_checker
// Port-level checks for the extract/deposit core, bound to the top level.
// ----------------------------------------------------------------------------
module pbxd_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input pbxd_pkg::word_type req_source_word,
   input pbxd_pkg::word_type req_select_mask,
   input logic               rsp_valid,
   input pbxd_pkg::word_type rsp_result_word
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("item produced no result");

   a_no_spurious: assert property (@(posedge clock)
      rsp_valid |-> $past(start, 3))
      else $error("result without item");

   a_empty_mask: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_select_mask == '0) |-> ##3 (rsp_result_word == '0))
      else $error("empty mask gave nonzero result");

   a_full_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_select_mask, 3) == '1)
         |-> (rsp_result_word == $past(req_source_word, 3)))
      else $error("full mask did not pass source through");

endmodule

bind parallel_bit_extract_deposit_core pbxd_checker u_pbxd_checker (.*);
